// File: hw/rtl/mprs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mprs_pkg
// Shared types and constants of the masked pattern range search block.
// ----------------------------------------------------------------------------
package mprs_pkg;

    localparam int PATTERN_BYTES     = 16;
    localparam int MAX_PATTERN_BYTES = 16;
    localparam int LEN_W             = 5;
    localparam int POS_W             = 32;
    localparam int OFFSET_W          = 31;
    localparam int CFG_DATA_W        = 64;
    localparam int CFG_INDEX_W       = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MASK_LOW       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MASK_HIGH      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_RANGE_START    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_RANGE_END      = 3'd6;

    typedef struct packed {
        logic [8*PATTERN_BYTES-1:0] pattern;
        logic [8*PATTERN_BYTES-1:0] mask;
        logic [LEN_W-1:0]           pattern_length;
        logic [OFFSET_W-1:0]        range_start;
        logic [OFFSET_W-1:0]        range_end;
    } search_cfg_t;

    typedef struct packed {
        logic                matched;
        logic [OFFSET_W-1:0] match_offset;
    } result_t;

endpackage

// File: hw/rtl/mprs_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mprs_scan
// Byte window, file position and per-byte masked compare. Produces at most
// one result per file in the cycle the byte is accepted.
// ----------------------------------------------------------------------------
module mprs_scan
    import mprs_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = mprs_pkg::MAX_PATTERN_BYTES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  search_cfg_t cfg,
    output logic        result_valid,
    output result_t     result
);

    localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN_BYTES);

    logic [7:0]       window_reg  [MAX_PATTERN_BYTES];
    logic [7:0]       window_next [MAX_PATTERN_BYTES];
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             done_reg;
    logic             done_next;

    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] len_m1;
    logic [POS_W-1:0] start_pos;
    logic             fits;
    logic             in_range;
    logic             lanes_ok;
    logic             hit;

    // Window as it stands once the incoming byte is shifted in.
    always_comb
    begin
        window_next[0] = data_byte;
        for (int i = 1; i < MAX_PATTERN_BYTES; i++)
        begin
            window_next[i] = window_reg[i-1];
        end
    end

    always_comb
    begin
        if (cfg.pattern_length == '0)
        begin
            len = LEN_W'(1);
        end
        else if (cfg.pattern_length > MAX_LEN)
        begin
            len = MAX_LEN;
        end
        else
        begin
            len = cfg.pattern_length;
        end
    end

    assign len_m1    = len - LEN_W'(1);
    assign fits      = pos_reg >= {{(POS_W-LEN_W){1'b0}}, len_m1};
    assign start_pos = pos_reg - {{(POS_W-LEN_W){1'b0}}, len_m1};
    assign in_range  = (start_pos >= {1'b0, cfg.range_start})
                    && (start_pos <= {1'b0, cfg.range_end});

    // Pattern byte k lines up with the byte that arrived len-1-k bytes ago.
    always_comb
    begin
        logic [LEN_W-1:0] sel;
        logic [7:0]       m;
        lanes_ok = 1'b1;
        for (int k = 0; k < MAX_PATTERN_BYTES; k++)
        begin
            sel = len_m1 - LEN_W'(k);
            m   = cfg.mask[8*k +: 8];
            if (LEN_W'(k) < len)
            begin
                if ((cfg.pattern[8*k +: 8] & m) != (window_next[sel[IDX_W-1:0]] & m))
                begin
                    lanes_ok = 1'b0;
                end
            end
        end
    end

    assign hit          = !done_reg && fits && in_range && lanes_ok;
    assign result_valid = accept && (hit || (last_byte && !done_reg));
    assign result.matched      = hit;
    assign result.match_offset = hit ? start_pos[OFFSET_W-1:0] : '0;

    always_comb
    begin
        pos_next  = pos_reg;
        done_next = done_reg;
        if (accept)
        begin
            if (last_byte)
            begin
                pos_next  = '0;
                done_next = 1'b0;
            end
            else
            begin
                done_next = done_reg | hit;
                if (pos_reg != '1)
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            done_reg <= 1'b0;
            for (int i = 0; i < MAX_PATTERN_BYTES; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else
        begin
            pos_reg  <= pos_next;
            done_reg <= done_next;
            if (accept)
            begin
                for (int i = 0; i < MAX_PATTERN_BYTES; i++)
                begin
                    window_reg[i] <= last_byte ? 8'h00 : window_next[i];
                end
            end
        end
    end

    // The last byte of a file always leaves the file state at its start.
    a_file_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_byte |=> (pos_reg == '0) && !done_reg)
        else $error("file state not cleared after last byte");

    // Once a result is out, the rest of the file gives nothing.
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !result_valid)
        else $error("second result within one file");

    // A match marks the file as finished unless the file ends right there.
    a_done_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        accept && hit && !last_byte |=> done_reg)
        else $error("match did not finish the search");

endmodule

// File: hw/rtl/mprs_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mprs_out_buf
// Two-entry result queue that decouples the output stall from the input.
// ----------------------------------------------------------------------------
module mprs_out_buf
    import mprs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t head
);

    localparam logic [1:0] FULL_COUNT = 2'd2;

    logic [1:0] count_reg;
    logic [1:0] count_next;
    result_t    slot0_reg;
    result_t    slot0_next;
    result_t    slot1_reg;
    result_t    slot1_next;
    logic       pop;

    assign pop       = out_valid && !out_stall;
    assign out_valid = count_reg != '0;
    assign full      = count_reg == FULL_COUNT;
    assign head      = slot0_reg;

    always_comb
    begin
        count_next = count_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (pop && push)
        begin
            if (count_reg == FULL_COUNT)
            begin
                slot0_next = slot1_reg;
                slot1_next = push_data;
            end
            else
            begin
                slot0_next = push_data;
            end
        end
        else if (pop)
        begin
            slot0_next = slot1_reg;
            count_next = count_reg - 2'd1;
        end
        else if (push)
        begin
            if (count_reg == '0)
            begin
                slot0_next = push_data;
            end
            else
            begin
                slot1_next = push_data;
            end
            count_next = count_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("result queue count out of range");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("result pushed into a full queue");

    a_push_to_empty: assert property (@(posedge clk) disable iff (!rst_n)
        push && (count_reg == '0) |=> out_valid && (head == $past(push_data)))
        else $error("result lost on push to empty queue");

endmodule

// File: hw/rtl/masked_pattern_range_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_pattern_range_search
// A result is registered in the result queue before it reaches the output.
// Throughput: one byte per cycle; the 16-lane masked compare and the range
// check sit between the window registers and a two-entry result queue.
// Input stalls only while both queue entries hold undelivered results.
// Reset (asynchronous, active low) loads the register reset values and
// clears the window, byte position and search state at once.
// ----------------------------------------------------------------------------
module masked_pattern_range_search
    import mprs_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = mprs_pkg::MAX_PATTERN_BYTES
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   write_enable,
    input  logic [CFG_INDEX_W-1:0] write_index,
    input  logic [CFG_DATA_W-1:0]  write_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             data_byte,
    input  logic                   last_byte,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   matched,
    output logic [OFFSET_W-1:0]    match_offset
);

    search_cfg_t cfg_reg;
    logic        accept;
    logic        result_valid;
    result_t     result;
    result_t     head;
    logic        full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern        <= '0;
            cfg_reg.mask           <= '1;
            cfg_reg.pattern_length <= LEN_W'(1);
            cfg_reg.range_start    <= '0;
            cfg_reg.range_end      <= '0;
        end
        else if (write_enable)
        begin
            case (write_index)
                REG_PATTERN_LOW:    cfg_reg.pattern[63:0]   <= write_data;
                REG_PATTERN_HIGH:   cfg_reg.pattern[127:64] <= write_data;
                REG_MASK_LOW:       cfg_reg.mask[63:0]      <= write_data;
                REG_MASK_HIGH:      cfg_reg.mask[127:64]    <= write_data;
                REG_PATTERN_LENGTH: cfg_reg.pattern_length  <= write_data[LEN_W-1:0];
                REG_RANGE_START:    cfg_reg.range_start     <= write_data[OFFSET_W-1:0];
                REG_RANGE_END:      cfg_reg.range_end       <= write_data[OFFSET_W-1:0];
                default:            ;
            endcase
        end
    end

    assign in_stall = full;
    assign accept   = in_valid && !in_stall;

    mprs_scan #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .cfg          (cfg_reg),
        .result_valid (result_valid),
        .result       (result)
    );

    mprs_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (result_valid),
        .push_data (result),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign matched      = head.matched;
    assign match_offset = head.match_offset;

endmodule

// File: bench/masked_pattern_range_search_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_pattern_range_search_tb
// Streams files through the search block one byte per transaction, under
// directed and random pattern, mask, length and range settings. A scoreboard
// predicts the single result of each file and checks every delivered result
// field by field, while both handshakes see random gaps and stalls.
// ----------------------------------------------------------------------------
import mprs_pkg::*;

typedef logic [7:0] file_bytes_t[$];

class match_tracker;
    logic [8*PATTERN_BYTES-1:0] pattern;
    logic [8*PATTERN_BYTES-1:0] mask;
    logic [LEN_W-1:0]           length_code;
    logic [OFFSET_W-1:0]        first_start;
    logic [OFFSET_W-1:0]        last_start;
    logic [7:0]                 window [MAX_PATTERN_BYTES];
    logic [POS_W-1:0]           position;
    bit                         file_done;
    result_t                    expected_results[$];
    int                         mismatches;

    function new();
        mismatches = 0;
        pattern = '0;
        mask = '1;
        length_code = LEN_W'(1);
        first_start = '0;
        last_start = '0;
        restart_file();
    endfunction

    function void restart_file();
        foreach (window[i])
            window[i] = 8'h00;
        position = '0;
        file_done = 1'b0;
    endfunction

    function void set_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        case (index)
            REG_PATTERN_LOW:    pattern[63:0] = value;
            REG_PATTERN_HIGH:   pattern[127:64] = value;
            REG_MASK_LOW:       mask[63:0] = value;
            REG_MASK_HIGH:      mask[127:64] = value;
            REG_PATTERN_LENGTH: length_code = value[LEN_W-1:0];
            REG_RANGE_START:    first_start = value[OFFSET_W-1:0];
            REG_RANGE_END:      last_start = value[OFFSET_W-1:0];
            default: ;
        endcase
    endfunction

    // Called for every accepted input transaction.
    function void note_byte(logic [7:0] data, logic last);
        int unsigned      len;
        logic [POS_W-1:0] start;
        bit               hit;
        result_t          res;

        len = 32'(length_code);
        if (len == 0)
            len = 1;
        if (len > MAX_PATTERN_BYTES)
            len = MAX_PATTERN_BYTES;

        for (int i = MAX_PATTERN_BYTES - 1; i > 0; i--)
            window[i] = window[i - 1];
        window[0] = data;

        if (!file_done && position >= len - 1)
        begin
            start = position - (len - 1);
            if (start >= POS_W'(first_start) && start <= POS_W'(last_start))
            begin
                hit = 1'b1;
                for (int k = 0; k < len; k++)
                begin
                    if ((pattern[8*k +: 8] & mask[8*k +: 8]) !=
                        (window[len - 1 - k] & mask[8*k +: 8]))
                        hit = 1'b0;
                end
                if (hit)
                begin
                    res.matched = 1'b1;
                    res.match_offset = start[OFFSET_W-1:0];
                    expected_results.push_back(res);
                    file_done = 1'b1;
                end
            end
        end

        if (last)
        begin
            if (!file_done)
            begin
                res.matched = 1'b0;
                res.match_offset = '0;
                expected_results.push_back(res);
            end
            restart_file();
        end
        else if (position != '1)
        begin
            position++;
        end
    endfunction

    // Called for every accepted result transaction.
    function void check_result(logic got_matched, logic [OFFSET_W-1:0] got_offset);
        result_t want;

        if (expected_results.size() == 0)
        begin
            $error("unexpected result: matched=%0b match_offset=%0d", got_matched, got_offset);
            mismatches++;
            return;
        end
        want = expected_results.pop_front();
        if (got_matched !== want.matched)
        begin
            $error("matched: expected %0b, actual %0b", want.matched, got_matched);
            mismatches++;
        end
        if (got_offset !== want.match_offset)
        begin
            $error("match_offset: expected %0d, actual %0d", want.match_offset, got_offset);
            mismatches++;
        end
    endfunction
endclass

module masked_pattern_range_search_tb;

    localparam int                  WATCHDOG_LIMIT = 2000;
    localparam int                  RANDOM_ITEMS   = 400;
    localparam logic [OFFSET_W-1:0] OFFSET_MAX     = '1;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   write_enable = 1'b0;
    logic [CFG_INDEX_W-1:0] write_index  = '0;
    logic [CFG_DATA_W-1:0]  write_data   = '0;
    logic                   in_valid     = 1'b0;
    logic                   in_stall;
    logic [7:0]             data_byte    = 8'h00;
    logic                   last_byte    = 1'b0;
    logic                   out_valid;
    logic                   out_stall    = 1'b0;
    logic                   matched;
    logic [OFFSET_W-1:0]    match_offset;

    match_tracker tracker;
    bit           quiet_in    = 1'b0;
    bit           quiet_out   = 1'b0;
    int unsigned  stall_left  = 0;
    int unsigned  idle_cycles = 0;
    int unsigned  random_items;

    always #5 clk = ~clk;

    masked_pattern_range_search u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .write_enable (write_enable),
        .write_index  (write_index),
        .write_data   (write_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .matched      (matched),
        .match_offset (match_offset)
    );

    function automatic int unsigned pick_gap();
        int unsigned roll;

        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(1, 3);
        if (roll < 94)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Result side: check accepted results and stall at random.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_result(matched, match_offset);
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (!quiet_out && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic last);
        int unsigned gap;

        gap = (quiet_in || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= value;
        last_byte <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.note_byte(value, last);
    endtask

    task automatic send_file(input file_bytes_t bytes);
        foreach (bytes[i])
            send_byte(bytes[i], i == bytes.size() - 1);
    endtask

    // Waits until every expected result has come and the block has gone quiet.
    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.expected_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        write_enable <= 1'b1;
        write_index <= index;
        write_data <= value;
        @(posedge clk);
        tracker.set_register(index, value);
    endtask

    task automatic load_settings(input logic [127:0] pat, input logic [127:0] msk,
                                 input logic [LEN_W-1:0] len,
                                 input logic [OFFSET_W-1:0] lo, input logic [OFFSET_W-1:0] hi);
        write_register(REG_PATTERN_LOW, pat[63:0]);
        write_register(REG_PATTERN_HIGH, pat[127:64]);
        write_register(REG_MASK_LOW, msk[63:0]);
        write_register(REG_MASK_HIGH, msk[127:64]);
        write_register(REG_PATTERN_LENGTH, CFG_DATA_W'(len));
        write_register(REG_RANGE_START, CFG_DATA_W'(lo));
        write_register(REG_RANGE_END, CFG_DATA_W'(hi));
        write_enable <= 1'b0;
    endtask

    initial
    begin
        logic [127:0]     pat;
        logic [127:0]     msk;
        file_bytes_t      bytes;
        logic [LEN_W-1:0] len_code;
        logic [OFFSET_W-1:0] lo;
        logic [OFFSET_W-1:0] hi;
        int unsigned      len_used;
        int unsigned      flen;
        int unsigned      at;
        int unsigned      choice;
        bit               alphabet;

        tracker = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: a one-byte pattern of zero, allowed at offset 0 only.
        bytes = {8'h00};
        send_file(bytes);
        bytes = {8'hFF};
        send_file(bytes);
        settle();

        // Bytes after the first match give nothing; unused lanes hold junk.
        pat = {$urandom, $urandom, $urandom, $urandom};
        msk = {$urandom, $urandom, $urandom, $urandom};
        pat[15:0] = 16'h6261;
        msk[15:0] = 16'hFFFF;
        load_settings(pat, msk, 5'd2, '0, 31'd100);
        bytes = {8'h61, 8'h62, 8'h61, 8'h62};
        send_file(bytes);
        settle();

        // Oversized length acts as 16; a case-blind mask; match on the last byte.
        pat = {$urandom, $urandom, $urandom, $urandom};
        msk = {16{8'hDF}};
        load_settings(pat, msk, 5'd31, '0, OFFSET_MAX);
        bytes = {};
        for (int k = 0; k < 16; k++)
            bytes.push_back(pat[8*k +: 8] ^ ($urandom_range(0, 1) ? 8'h20 : 8'h00));
        send_file(bytes);
        settle();

        // Length zero acts as one.
        pat = {$urandom, $urandom, $urandom, $urandom};
        pat[7:0] = 8'h5A;
        load_settings(pat, '1, 5'd0, '0, '0);
        bytes = {8'h5A};
        send_file(bytes);
        settle();

        // The range lies past the last place the pattern could fit.
        load_settings(pat, '1, 5'd3, 31'd2, OFFSET_MAX);
        bytes = {pat[7:0], pat[15:8], pat[23:16], pat[7:0]};
        send_file(bytes);
        settle();

        // Range start above range end admits nothing.
        load_settings(pat, '1, 5'd1, 31'd9, 31'd4);
        bytes = {8'h5A};
        send_file(bytes);
        settle();

        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            quiet_in = ($urandom_range(0, 4) == 0);
            quiet_out = ($urandom_range(0, 4) == 0);

            pat = {$urandom, $urandom, $urandom, $urandom};
            choice = $urandom_range(0, 9);
            if (choice < 6)
                len_used = $urandom_range(1, 4);
            else if (choice < 9)
                len_used = $urandom_range(5, 16);
            else
                len_used = 16;
            len_code = LEN_W'(len_used);
            if (choice == 9)
            begin
                len_code = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(17, 31));
                len_used = (len_code == 0) ? 1 : 16;
            end

            msk = '1;
            choice = $urandom_range(0, 3);
            if (choice >= 2)
            begin
                for (int k = 0; k < 16; k++)
                    msk[8*k +: 8] = (choice == 3 || $urandom_range(0, 1))
                                  ? 8'($urandom) : 8'hFF;
            end

            choice = $urandom_range(0, 9);
            if (choice < 4)
            begin
                lo = '0;
                hi = OFFSET_MAX;
            end
            else if (choice < 7)
            begin
                lo = OFFSET_W'($urandom_range(0, 12));
                hi = OFFSET_W'(lo + $urandom_range(0, 8));
            end
            else if (choice == 7)
            begin
                lo = OFFSET_W'($urandom_range(1, 30));
                hi = OFFSET_W'($urandom_range(0, lo - 1));
            end
            else if (choice == 8)
            begin
                lo = OFFSET_W'($urandom_range(0, OFFSET_MAX));
                hi = OFFSET_MAX;
            end
            else
            begin
                lo = '0;
                hi = OFFSET_W'($urandom_range(0, 30));
            end
            load_settings(pat, msk, len_code, lo, hi);

            repeat ($urandom_range(1, 3))
            begin
                flen = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 48)
                                                   : $urandom_range(1, 20);
                // A small alphabet drawn from the pattern makes near misses common.
                alphabet = ($urandom_range(0, 2) == 0);
                bytes = {};
                for (int i = 0; i < flen; i++)
                    bytes.push_back(alphabet ? pat[8*$urandom_range(0, len_used - 1) +: 8]
                                             : 8'($urandom));
                if (flen >= len_used && $urandom_range(0, 9) < 6)
                begin
                    at = $urandom_range(0, flen - len_used);
                    for (int k = 0; k < len_used; k++)
                        bytes[at + k] = (pat[8*k +: 8] & msk[8*k +: 8]) |
                                        (8'($urandom) & ~msk[8*k +: 8]);
                end
                send_file(bytes);
                random_items += flen;
            end
            settle();
        end

        repeat (5) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/mprs_pkg.sv
hw/rtl/mprs_scan.sv
hw/rtl/mprs_out_buf.sv
hw/rtl/masked_pattern_range_search.sv
bench/masked_pattern_range_search_tb.sv
